FILE: hdl/dkwl_pkg.sv
// Package for the depth keypoint window lookup block.
// Item types, register indexes, state encoding and store sizing.
// No dependencies.
package dkwl_pkg;

    localparam int MaxWidth        = 640;
    localparam int MaxHeight       = 480;
    localparam int HalfWindowLimit = 15;
    localparam int StoreDepth      = MaxWidth * MaxHeight;
    localparam int AddrW           = $clog2(StoreDepth);
    localparam int ColW            = 10;
    localparam int RowW            = 9;
    localparam int CntW            = 10;  // up to 31*31 = 961 points
    localparam int SumW            = 16 + CntW;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_MIN_DEPTH    = 3'd2,
        CFG_MAX_DEPTH    = 3'd3,
        CFG_MAX_HALF     = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               operation;
        logic [ColW-1:0]    column;
        logic [RowW-1:0]    row;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [3:0]         window_half;
        logic signed [15:0] avg_x;
        logic signed [15:0] avg_y;
        logic signed [15:0] avg_z;
    } out_item_t;

endpackage

FILE: hdl/dkwl_divider.sv
// Restoring signed divider for the window mean, one quotient bit per cycle.
// Divides three sums by one count, truncating toward zero. Uses dkwl_pkg.
module dkwl_divider
    import dkwl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [SumW-1:0] sum_x,
    input  logic signed [SumW-1:0] sum_y,
    input  logic signed [SumW-1:0] sum_z,
    input  logic [CntW-1:0]        count,
    output logic                   done,
    output logic signed [15:0]     quo_x,
    output logic signed [15:0]     quo_y,
    output logic signed [15:0]     quo_z
);

    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]  nx_reg, ny_reg, nz_reg;
    logic [SumW-1:0]  rx_reg, ry_reg, rz_reg;
    logic [2:0]       neg_reg;
    logic [CntW-1:0]  d_reg;
    logic [StepW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SumW-1:0]  tx, ty, tz;

    function automatic logic [SumW-1:0] absv(input logic signed [SumW-1:0] v);
        return v[SumW-1] ? SumW'(-v) : SumW'(v);
    endfunction

    assign tx = {rx_reg[SumW-2:0], nx_reg[SumW-1]};
    assign ty = {ry_reg[SumW-2:0], ny_reg[SumW-1]};
    assign tz = {rz_reg[SumW-2:0], nz_reg[SumW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= StepW'(SumW);
                nx_reg   <= absv(sum_x);
                ny_reg   <= absv(sum_y);
                nz_reg   <= absv(sum_z);
                neg_reg  <= {sum_x[SumW-1], sum_y[SumW-1], sum_z[SumW-1]};
                rx_reg   <= '0;
                ry_reg   <= '0;
                rz_reg   <= '0;
                d_reg    <= count;
            end else if (busy_reg) begin
                nx_reg <= {nx_reg[SumW-2:0], tx >= SumW'(d_reg)};
                ny_reg <= {ny_reg[SumW-2:0], ty >= SumW'(d_reg)};
                nz_reg <= {nz_reg[SumW-2:0], tz >= SumW'(d_reg)};
                rx_reg <= (tx >= SumW'(d_reg)) ? tx - SumW'(d_reg) : tx;
                ry_reg <= (ty >= SumW'(d_reg)) ? ty - SumW'(d_reg) : ty;
                rz_reg <= (tz >= SumW'(d_reg)) ? tz - SumW'(d_reg) : tz;
                step_reg <= step_reg - 1'b1;
                if (step_reg == StepW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign quo_x = neg_reg[2] ? 16'(-nx_reg) : nx_reg[15:0];
    assign quo_y = neg_reg[1] ? 16'(-ny_reg) : ny_reg[15:0];
    assign quo_z = neg_reg[0] ? 16'(-nz_reg) : nz_reg[15:0];

endmodule

FILE: hdl/depth_keypoint_window_lookup.sv
// Depth keypoint window lookup: point frame store with hole-filling query.
// Load item: accepted back to back. Query: a valid centre in depth range is returned
// directly; else windows h=1..limit are scanned point by point through the single
// store read port and the first window with hits is averaged by the divider.
// Inputs stall while a query runs or a result waits. Reset is synchronous active low;
// config and control registers return to defaults, data registers and store undefined.
module depth_keypoint_window_lookup
    import dkwl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [47:0] store_mem [StoreDepth];
    logic [47:0] rd_data_reg;

    logic [9:0]  fw_reg;
    logic [8:0]  fh_reg;
    logic [15:0] min_reg, max_reg;
    logic [3:0]  mh_reg;

    state_t state_reg, state_next;
    logic [ColW-1:0] qc_reg;
    logic [RowW-1:0] qr_reg;
    logic [3:0]  h_reg, h_next;
    logic signed [11:0] c_reg, c_next, r_reg, r_next;
    logic        pend_reg, pend_next;
    logic signed [SumW-1:0] sx_reg, sy_reg, sz_reg;
    logic [CntW-1:0] n_reg;
    logic        clr;
    out_item_t   out_reg, out_next;
    logic        mv_reg, mv_next;
    logic        div_start;
    logic        div_done;
    logic signed [15:0] qx, qy, qz;

    logic        s_fire;
    logic [9:0]  efw;
    logic [8:0]  efh;
    logic        in_frame;
    logic [AddrW-1:0] rd_addr;
    logic        rd_en;
    logic signed [15:0] rd_z;
    logic        rd_ok;
    logic [3:0]  limit;

    assign efw = (fw_reg < 10'(MaxWidth)) ? fw_reg : 10'(MaxWidth);
    assign efh = (fh_reg < 9'(MaxHeight)) ? fh_reg : 9'(MaxHeight);
    assign limit = (mh_reg < 4'(HalfWindowLimit)) ? mh_reg : 4'(HalfWindowLimit);
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign s_fire  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign rd_z  = rd_data_reg[15:0];
    assign rd_ok = $signed({1'b0, min_reg}) <= 17'(rd_z)
                && 17'(rd_z) <= $signed({1'b0, max_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 10'd640;
            fh_reg <= 9'd480;
            min_reg <= 16'd400;
            max_reg <= 16'd4000;
            mh_reg <= 4'd15;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_data[9:0];
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_data[8:0];
                CFG_MIN_DEPTH:    min_reg <= cfg_data;
                CFG_MAX_DEPTH:    max_reg <= cfg_data;
                CFG_MAX_HALF:     mh_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.operation == OP_LOAD
            && 10'(s_data.column) < efw && 9'(s_data.row) < efh) begin
            store_mem[AddrW'(s_data.row) * AddrW'(MaxWidth) + AddrW'(s_data.column)]
                <= {s_data.point_x, s_data.point_y, s_data.point_z};
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb begin
        in_frame = !c_reg[11] && !r_reg[11]
                && c_reg[10:0] < 11'(efw) && r_reg[10:0] < 11'(efh);
        rd_en   = 1'b0;
        rd_addr = AddrW'(r_reg[8:0]) * AddrW'(MaxWidth) + AddrW'(c_reg[9:0]);
        if (s_fire) begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(s_data.row) * AddrW'(MaxWidth) + AddrW'(s_data.column);
        end else if (state_reg == ST_SCAN && in_frame) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        h_next = h_reg;
        c_next = c_reg;
        r_next = r_reg;
        pend_next = 1'b0;
        clr = 1'b0;
        div_start = 1'b0;
        out_next = out_reg;
        mv_next = mv_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.operation == OP_QUERY) begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: begin
                clr = 1'b1;
                if (10'(qc_reg) < efw && 9'(qr_reg) < efh && rd_ok) begin
                    out_next = '{1'b1, 4'd0, rd_data_reg[47:32],
                                 rd_data_reg[31:16], rd_data_reg[15:0]};
                    state_next = ST_OUT;
                end else if (limit == 4'd0) begin
                    out_next = '0;
                    state_next = ST_OUT;
                end else begin
                    h_next = 4'd1;
                    c_next = 12'(qc_reg) - 12'sd1;
                    r_next = 12'(qr_reg) - 12'sd1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next = in_frame;
                if (c_reg == 12'(qc_reg) + 12'(h_reg)) begin
                    c_next = 12'(qc_reg) - 12'(h_reg);
                    r_next = r_reg + 12'sd1;
                    if (r_reg == 12'(qr_reg) + 12'(h_reg)) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    c_next = c_reg + 12'sd1;
                end
            end
            ST_DRAIN: begin
                // wait for the last read of the window to reach the sums
                if (pend_reg) begin
                    state_next = ST_DRAIN;
                end else if (n_reg != '0) begin
                    div_start = 1'b1;
                    state_next = ST_DIVIDE;
                end else if (h_reg == limit) begin
                    out_next = '0;
                    state_next = ST_OUT;
                end else begin
                    clr = 1'b1;
                    h_next = h_reg + 4'd1;
                    c_next = 12'(qc_reg) - 12'(h_reg) - 12'sd1;
                    r_next = 12'(qr_reg) - 12'(h_reg) - 12'sd1;
                    state_next = ST_SCAN;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    out_next = '{1'b1, h_reg, qx, qy, qz};
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            qc_reg <= s_data.column;
            qr_reg <= s_data.row;
        end
        h_reg <= h_next;
        c_reg <= c_next;
        r_reg <= r_next;
        out_reg <= out_next;
        if (clr) begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            n_reg <= '0;
        end else if (pend_reg && rd_ok) begin
            sx_reg <= sx_reg + SumW'($signed(rd_data_reg[47:32]));
            sy_reg <= sy_reg + SumW'($signed(rd_data_reg[31:16]));
            sz_reg <= sz_reg + SumW'($signed(rd_data_reg[15:0]));
            n_reg <= n_reg + 1'b1;
        end
    end

    dkwl_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum_x   (sx_reg),
        .sum_y   (sy_reg),
        .sum_z   (sz_reg),
        .count   (n_reg),
        .done    (div_done),
        .quo_x   (qx),
        .quo_y   (qy),
        .quo_z   (qz)
    );

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready while busy");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> n_reg != '0) else $error("divide by zero count");
    a_out_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.window_half == 4'd0)
        else $error("bad not-found item");

endmodule
